// ===== rtl/lsre_pkg.sv =====
// Package for the layered sparse image run-length encoder.
// Holds field widths, reset addresses, register indexes and the command word
// passed from the front end to the write sequencer. Depends on nothing.
package lsre_pkg;

   localparam int ADDR_W  = 28;
   localparam int DATA_W  = 32;
   localparam int PIX_W   = 23;
   localparam int FRUN_W  = 27;
   localparam int FPIX_W  = 7;
   localparam int NL_W    = 5;
   localparam int CSR_W   = 23;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = 2;
   localparam int NSTEP   = 10;

   localparam logic [ADDR_W-1:0] WP_RESET  = 28'd10;
   localparam logic [ADDR_W-1:0] RHA_RESET = 28'd7;
   localparam logic [ADDR_W-1:0] SIZE_ADDR = 28'd6;
   localparam logic [NL_W-1:0]   LAYER_COUNT_RESET = 5'd1;
   localparam logic [PIX_W-1:0]  PIXEL_COUNT_RESET = 23'd1;

   typedef enum logic [0:0] {
      CSR_LAYER_COUNT = 1'b0,
      CSR_PIXEL_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      STEP_CLOSE_INACT = 4'd0,
      STEP_CLOSE_ACT   = 4'd1,
      STEP_CLOSE_FRAG  = 4'd2,
      STEP_COLOR       = 4'd3,
      STEP_DEPTH       = 4'd4,
      STEP_COUNT       = 4'd5,
      STEP_END_INACT   = 4'd6,
      STEP_END_ACT     = 4'd7,
      STEP_END_FRAG    = 4'd8,
      STEP_SIZE        = 4'd9
   } step_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  inactive;
      logic [PIX_W-1:0]  active;
      logic [FRUN_W-1:0] frags;
   } header_type;

   typedef struct packed {
      logic              close_en;
      header_type        close_hdr;
      logic              pair_en;
      logic [ADDR_W-1:0] pair_addr;
      logic [DATA_W-1:0] color;
      logic [DATA_W-1:0] depth;
      logic              count_en;
      logic [ADDR_W-1:0] count_addr;
      logic [FPIX_W-1:0] count_val;
      logic              end_en;
      header_type        end_hdr;
      logic [DATA_W-1:0] size;
   } cmd_type;

endpackage

// ===== rtl/lsre_req_if.sv =====
// Fragment channel: one word carries the colour and depth of one fragment.
// Valid/ready handshake; no dependencies.
interface lsre_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] frag_color;
   logic [31:0] frag_depth;

   modport source (output valid, output frag_color, output frag_depth, input ready);
   modport sink (input valid, input frag_color, input frag_depth, output ready);
endinterface

// ===== rtl/lsre_rsp_if.sv =====
// Write channel: one word is a single 32-bit store into the image buffer.
// Valid/ready handshake; no dependencies.
interface lsre_rsp_if;
   logic        valid;
   logic        ready;
   logic [27:0] write_addr;
   logic [31:0] write_data;
   logic        last;

   modport source (output valid, output write_addr, output write_data, output last,
                   input ready);
   modport sink (input valid, input write_addr, input write_data, input last,
                 output ready);
endinterface

// ===== rtl/lsre_front.sv =====
// Front end: accepts fragments, tracks pixel, run and image state, and
// turns each fragment into at most one command word. Depends on lsre_pkg, lsre_req_if.
module lsre_front #(
   parameter int MAX_LAYERS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   lsre_req_if.sink                       req_ch,
   input  logic [lsre_pkg::NL_W-1:0]      layer_count,
   input  logic [lsre_pkg::PIX_W-1:0]     pixel_count,
   input  logic                           q_full,
   output logic                           push,
   output lsre_pkg::cmd_type              cmd
);
   import lsre_pkg::*;

   localparam int LPOS_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int LAY_W  = $clog2(MAX_LAYERS + 1);
   localparam int CMP_W  = ((LAY_W > NL_W) ? LAY_W : NL_W) + 1;

   logic [ADDR_W-1:0] wp_ff, wp_in, rha_ff, rha_in, csa_ff, csa_in;
   logic [PIX_W-1:0]  inact_ff, inact_in, act_ff, act_in, ppos_ff, ppos_in;
   logic [FRUN_W-1:0] frag_ff, frag_in;
   logic [FPIX_W-1:0] fpix_ff, fpix_in;
   logic [LPOS_W-1:0] lpos_ff, lpos_in;
   logic              prev_ff, prev_in, skip_ff, skip_in;
   logic [CMP_W-1:0]  layers;
   logic [PIX_W-1:0]  pixels;
   logic              accept;
   cmd_type           cmd_c;

   assign req_ch.ready = !q_full;
   assign accept = req_ch.valid && !q_full;

   always_comb begin
      logic [CMP_W-1:0] nl_ext;
      logic [CMP_W-1:0] max_ext;
      nl_ext  = CMP_W'(layer_count);
      max_ext = CMP_W'(MAX_LAYERS);
      if (nl_ext == '0) begin
         layers = CMP_W'(1);
      end else if (nl_ext > max_ext) begin
         layers = max_ext;
      end else begin
         layers = nl_ext;
      end
      pixels = (pixel_count == '0) ? PIX_W'(1) : pixel_count;
   end

   always_comb begin
      logic alpha_zero;
      alpha_zero = (req_ch.frag_color[31:24] == 8'd0);
      wp_in    = wp_ff;
      rha_in   = rha_ff;
      csa_in   = csa_ff;
      inact_in = inact_ff;
      act_in   = act_ff;
      frag_in  = frag_ff;
      fpix_in  = fpix_ff;
      prev_in  = prev_ff;
      lpos_in  = lpos_ff;
      ppos_in  = ppos_ff;
      skip_in  = skip_ff;
      cmd_c    = '0;
      cmd_c.color = req_ch.frag_color;
      cmd_c.depth = req_ch.frag_depth;

      if (lpos_ff == '0) begin
         if (alpha_zero) begin
            if (prev_ff) begin
               cmd_c.close_en           = 1'b1;
               cmd_c.close_hdr.addr     = rha_ff;
               cmd_c.close_hdr.inactive = inact_ff;
               cmd_c.close_hdr.active   = act_ff;
               cmd_c.close_hdr.frags    = frag_ff;
               rha_in   = wp_ff;
               wp_in    = wp_ff + ADDR_W'(3);
               inact_in = '0;
               act_in   = '0;
               frag_in  = '0;
               prev_in  = 1'b0;
            end
            inact_in = inact_in + PIX_W'(1);
            fpix_in  = '0;
            skip_in  = 1'b1;
         end else begin
            csa_in          = wp_ff;
            cmd_c.pair_en   = 1'b1;
            cmd_c.pair_addr = wp_ff + ADDR_W'(1);
            wp_in           = wp_ff + ADDR_W'(3);
            fpix_in         = FPIX_W'(1);
            skip_in         = 1'b0;
         end
      end else if (!skip_ff) begin
         if (alpha_zero) begin
            skip_in = 1'b1;
         end else begin
            cmd_c.pair_en   = 1'b1;
            cmd_c.pair_addr = wp_ff;
            wp_in           = wp_ff + ADDR_W'(2);
            fpix_in         = fpix_ff + FPIX_W'(1);
         end
      end

      if ((CMP_W'(lpos_ff) + CMP_W'(1)) >= layers) begin
         if (fpix_in != '0) begin
            cmd_c.count_en   = 1'b1;
            cmd_c.count_addr = csa_in;
            cmd_c.count_val  = fpix_in;
            act_in  = act_in + PIX_W'(1);
            frag_in = frag_in + FRUN_W'(fpix_in);
            prev_in = 1'b1;
         end
         fpix_in = '0;
         skip_in = 1'b0;
         lpos_in = '0;
         ppos_in = ppos_ff + PIX_W'(1);
         if (ppos_in >= pixels) begin
            cmd_c.end_en           = 1'b1;
            cmd_c.end_hdr.addr     = rha_in;
            cmd_c.end_hdr.inactive = inact_in;
            cmd_c.end_hdr.active   = act_in;
            cmd_c.end_hdr.frags    = frag_in;
            cmd_c.size             = {2'b00, wp_in, 2'b00};
            wp_in    = WP_RESET;
            rha_in   = RHA_RESET;
            inact_in = '0;
            act_in   = '0;
            frag_in  = '0;
            csa_in   = '0;
            prev_in  = 1'b0;
            ppos_in  = '0;
         end
      end else begin
         lpos_in = lpos_ff + LPOS_W'(1);
      end
   end

   assign cmd  = cmd_c;
   assign push = accept && (cmd_c.close_en || cmd_c.pair_en || cmd_c.count_en ||
                            cmd_c.end_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= WP_RESET;
         rha_ff   <= RHA_RESET;
         csa_ff   <= '0;
         inact_ff <= '0;
         act_ff   <= '0;
         frag_ff  <= '0;
         fpix_ff  <= '0;
         prev_ff  <= 1'b0;
         lpos_ff  <= '0;
         ppos_ff  <= '0;
         skip_ff  <= 1'b0;
      end else if (accept) begin
         wp_ff    <= wp_in;
         rha_ff   <= rha_in;
         csa_ff   <= csa_in;
         inact_ff <= inact_in;
         act_ff   <= act_in;
         frag_ff  <= frag_in;
         fpix_ff  <= fpix_in;
         prev_ff  <= prev_in;
         lpos_ff  <= lpos_in;
         ppos_ff  <= ppos_in;
         skip_ff  <= skip_in;
      end
   end

endmodule

// ===== rtl/lsre_queue.sv =====
// Short command queue between the front end and the write sequencer.
// Depends on lsre_pkg.
module lsre_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lsre_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output lsre_pkg::cmd_type head_cmd
);
   import lsre_pkg::*;

   cmd_type             mem [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_pop;

   assign full       = (count_ff == (QPTR_W + 1)'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/lsre_back.sv =====
// Write sequencer: walks the words of the command at the queue head and
// drives them through an output register. Depends on lsre_pkg, lsre_rsp_if.
module lsre_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  lsre_pkg::cmd_type head_cmd,
   output logic              pop,
   lsre_rsp_if.source        rsp_ch
);
   import lsre_pkg::*;

   logic [NSTEP-1:0]  done_ff, done_in, mask, remaining, sel;
   logic              valid_ff, valid_in, load, is_last;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              last_ff;
   step_type          step;

   assign mask = {head_cmd.end_en, {3{head_cmd.end_en}}, head_cmd.count_en,
                  {2{head_cmd.pair_en}}, {3{head_cmd.close_en}}};
   assign remaining = mask & ~done_ff;
   assign sel       = remaining & (~remaining + NSTEP'(1));
   assign is_last   = ((remaining & ~sel) == '0);
   assign load      = head_valid && (!valid_ff || rsp_ch.ready);
   assign pop       = load && is_last;

   always_comb begin
      step = STEP_CLOSE_INACT;
      for (int i = 0; i < NSTEP; i++) begin
         if (sel[i]) begin
            step = step_type'(4'(i));
         end
      end
   end

   always_comb begin
      case (step)
         STEP_CLOSE_INACT: begin
            addr_in = head_cmd.close_hdr.addr;
            data_in = DATA_W'(head_cmd.close_hdr.inactive);
         end
         STEP_CLOSE_ACT: begin
            addr_in = head_cmd.close_hdr.addr + ADDR_W'(1);
            data_in = DATA_W'(head_cmd.close_hdr.active);
         end
         STEP_CLOSE_FRAG: begin
            addr_in = head_cmd.close_hdr.addr + ADDR_W'(2);
            data_in = DATA_W'(head_cmd.close_hdr.frags);
         end
         STEP_COLOR: begin
            addr_in = head_cmd.pair_addr;
            data_in = head_cmd.color;
         end
         STEP_DEPTH: begin
            addr_in = head_cmd.pair_addr + ADDR_W'(1);
            data_in = head_cmd.depth;
         end
         STEP_COUNT: begin
            addr_in = head_cmd.count_addr;
            data_in = DATA_W'(head_cmd.count_val);
         end
         STEP_END_INACT: begin
            addr_in = head_cmd.end_hdr.addr;
            data_in = DATA_W'(head_cmd.end_hdr.inactive);
         end
         STEP_END_ACT: begin
            addr_in = head_cmd.end_hdr.addr + ADDR_W'(1);
            data_in = DATA_W'(head_cmd.end_hdr.active);
         end
         STEP_END_FRAG: begin
            addr_in = head_cmd.end_hdr.addr + ADDR_W'(2);
            data_in = DATA_W'(head_cmd.end_hdr.frags);
         end
         STEP_SIZE: begin
            addr_in = SIZE_ADDR;
            data_in = head_cmd.size;
         end
         default: begin
            addr_in = '0;
            data_in = '0;
         end
      endcase
   end

   always_comb begin
      done_in  = done_ff;
      valid_in = valid_ff;
      if (load) begin
         done_in  = is_last ? '0 : (done_ff | sel);
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         addr_ff <= addr_in;
         data_ff <= data_in;
         last_ff <= is_last;
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.write_addr = addr_ff;
   assign rsp_ch.write_data = data_ff;
   assign rsp_ch.last       = last_ff;

endmodule

// ===== rtl/layered_sparse_image_rle_encoder.sv =====
// Layered sparse image run-length encoder. Each accepted word is one fragment;
// it causes zero to seven 32-bit store words on the write channel, the final
// one flagged last. The write channel issues one word per cycle while the
// receiver is ready. A fragment of an active pixel causes two words (colour
// and depth), a closing layer adds one for the count word, and closing a run
// or the image adds three or four. The front end takes a fragment in every
// cycle while the four-entry command queue has room, so short bursts of
// costly items are absorbed. Configuration takes effect at once and should
// be written while the block is idle.
module layered_sparse_image_rle_encoder #(
   parameter int MAX_LAYERS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   lsre_req_if.sink                    req_ch,
   lsre_rsp_if.source                  rsp_ch,
   input  logic                        csr_we,
   input  lsre_pkg::csr_index_type     csr_index,
   input  logic [lsre_pkg::CSR_W-1:0]  csr_wdata
);
   import lsre_pkg::*;

   logic [NL_W-1:0]  layer_count_ff, layer_count_in;
   logic [PIX_W-1:0] pixel_count_ff, pixel_count_in;
   logic             push, full, pop, head_valid;
   cmd_type          push_cmd, head_cmd;

   always_comb begin
      layer_count_in = layer_count_ff;
      pixel_count_in = pixel_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LAYER_COUNT: layer_count_in = csr_wdata[NL_W-1:0];
            CSR_PIXEL_COUNT: pixel_count_in = csr_wdata[PIX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff <= LAYER_COUNT_RESET;
         pixel_count_ff <= PIXEL_COUNT_RESET;
      end else begin
         layer_count_ff <= layer_count_in;
         pixel_count_ff <= pixel_count_in;
      end
   end

   lsre_front #(
      .MAX_LAYERS (MAX_LAYERS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .layer_count (layer_count_ff),
      .pixel_count (pixel_count_ff),
      .q_full      (full),
      .push        (push),
      .cmd         (push_cmd)
   );

   lsre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   lsre_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ===== tb/layered_sparse_image_rle_encoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the layered sparse image run-length encoder.
// A directed table is followed by random layered pixels, with every store word
// compared against listed known words or an in-bench encoder. Depends on lsre_pkg, both channels and the encoder.
module layered_sparse_image_rle_encoder_tb;
   import lsre_pkg::*;

   localparam int MAX_LAYERS = 16;
   localparam int SETTLE = 16;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TOTAL_FRAGS = 395;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic              last;
   } image_write_type;

   typedef struct {
      bit                is_csr;
      csr_index_type     index;
      logic [CSR_W-1:0]  value;
      logic [DATA_W-1:0] color;
      logic [DATA_W-1:0] depth;
      int                known_n;
      int                known_at;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [CSR_W-1:0] csr_wdata;

   lsre_req_if req_ch ();
   lsre_rsp_if rsp_ch ();

   layered_sparse_image_rle_encoder #(.MAX_LAYERS(MAX_LAYERS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Encoder state mirrored in the bench.
   logic [NL_W-1:0]   cfg_layers;
   logic [PIX_W-1:0]  cfg_pixels;
   logic [ADDR_W-1:0] wp;
   logic [ADDR_W-1:0] hdr_addr;
   logic [PIX_W-1:0]  run_inactive;
   logic [PIX_W-1:0]  run_active;
   logic [FRUN_W-1:0] run_frags;
   logic [ADDR_W-1:0] count_addr;
   logic [4:0]        pix_frags;
   logic              prev_active;
   logic [3:0]        layer_pos;
   logic [PIX_W-1:0]  pixel_pos;
   logic              skipping;

   image_write_type pending_writes[$];
   image_write_type step_writes[$];
   image_write_type known_words[$];
   stim_row_type    directed_rows[$];

   int layer_plan [10] = '{1, 16, 3, 0, 31, 2, 17, 5, 8, 4};
   int pixel_plan [10] = '{1, 2, 4194304, 3, 0, 8388607, 5, 1, 2, 6};

   int  frags_sent = 0;
   int  words_checked = 0;
   int  images_done = 0;
   int  csr_writes = 0;
   int  error_count = 0;
   int  cycle_count = 0;
   bit  req_gaps_on = 1'b1;
   bit  rsp_gaps_on = 1'b1;
   bit  hold_writes = 1'b0;

   function automatic int active_layers();
      if (cfg_layers == 0) return 1;
      if (cfg_layers > MAX_LAYERS) return MAX_LAYERS;
      return int'(cfg_layers);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_write(input logic [ADDR_W-1:0] addr,
                                     input logic [DATA_W-1:0] data);
      image_write_type w;
      w.addr = addr;
      w.data = data;
      w.last = 1'b0;
      step_writes.push_back(w);
   endfunction

   function automatic void add_header();
      add_write(hdr_addr, 32'(run_inactive));
      add_write(hdr_addr + 28'd1, 32'(run_active));
      add_write(hdr_addr + 28'd2, 32'(run_frags));
   endfunction

   function automatic void clear_image();
      wp           = WP_RESET;
      hdr_addr     = RHA_RESET;
      run_inactive = '0;
      run_active   = '0;
      run_frags    = '0;
      count_addr   = '0;
      pix_frags    = '0;
      prev_active  = 1'b0;
      layer_pos    = '0;
      pixel_pos    = '0;
      skipping     = 1'b0;
   endfunction

   // Works out the store words that one fragment causes and advances the state.
   function automatic void encode_fragment(input logic [DATA_W-1:0] color,
                                           input logic [DATA_W-1:0] depth);
      bit alpha_zero;
      int layers;
      int pixels;
      image_write_type w;
      step_writes.delete();
      alpha_zero = (color[31:24] == 8'h00);
      layers = active_layers();
      pixels = (cfg_pixels == 0) ? 1 : int'(cfg_pixels);
      if (layer_pos == 0) begin
         if (alpha_zero) begin
            if (prev_active) begin
               add_header();
               hdr_addr     = wp;
               wp           = wp + 28'd3;
               run_inactive = '0;
               run_active   = '0;
               run_frags    = '0;
               prev_active  = 1'b0;
            end
            run_inactive = run_inactive + 23'd1;
            pix_frags = '0;
            skipping = 1'b1;
         end else begin
            count_addr = wp;
            add_write(wp + 28'd1, color);
            add_write(wp + 28'd2, depth);
            wp = wp + 28'd3;
            pix_frags = 5'd1;
            skipping = 1'b0;
         end
      end else if (!skipping) begin
         if (alpha_zero) begin
            skipping = 1'b1;
         end else begin
            add_write(wp, color);
            add_write(wp + 28'd1, depth);
            wp = wp + 28'd2;
            pix_frags = pix_frags + 5'd1;
         end
      end
      if (int'(layer_pos) + 1 >= layers) begin
         if (pix_frags != 0) begin
            add_write(count_addr, 32'(pix_frags));
            run_active = run_active + 23'd1;
            run_frags = run_frags + 27'(pix_frags);
            prev_active = 1'b1;
         end
         pix_frags = '0;
         skipping = 1'b0;
         layer_pos = '0;
         pixel_pos = pixel_pos + 23'd1;
         if (int'(pixel_pos) >= pixels) begin
            add_header();
            add_write(SIZE_ADDR, 32'({wp, 2'b00}));
            clear_image();
            images_done++;
         end
      end else begin
         layer_pos = layer_pos + 4'd1;
      end
      if (step_writes.size() > 0) begin
         w = step_writes.pop_back();
         w.last = 1'b1;
         step_writes.push_back(w);
      end
   endfunction

   function automatic stim_row_type frag_row(input logic [DATA_W-1:0] color,
                                             input logic [DATA_W-1:0] depth,
                                             input int known_n, input int known_at);
      stim_row_type r;
      r.is_csr   = 1'b0;
      r.index    = CSR_LAYER_COUNT;
      r.value    = '0;
      r.color    = color;
      r.depth    = depth;
      r.known_n  = known_n;
      r.known_at = known_at;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input csr_index_type index,
                                            input logic [CSR_W-1:0] value);
      stim_row_type r;
      r = frag_row('0, '0, 0, 0);
      r.is_csr = 1'b1;
      r.index  = index;
      r.value  = value;
      return r;
   endfunction

   function automatic void add_known(input logic [ADDR_W-1:0] addr,
                                     input logic [DATA_W-1:0] data, input logic last);
      image_write_type w;
      w.addr = addr;
      w.data = data;
      w.last = last;
      known_words.push_back(w);
   endfunction

   // Offers one fragment word and files its expected store words on acceptance.
   task automatic send_frag(input logic [DATA_W-1:0] color, input logic [DATA_W-1:0] depth,
                            input int known_n, input int known_at);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.frag_color <= color;
      req_ch.frag_depth <= depth;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      encode_fragment(color, depth);
      frags_sent++;
      if (known_n > 0) begin
         for (int i = 0; i < known_n; i++) pending_writes.push_back(known_words[known_at + i]);
      end else begin
         foreach (step_writes[i]) pending_writes.push_back(step_writes[i]);
      end
      @(negedge clock);
   endtask

   task automatic drain_writes();
      req_ch.valid <= 1'b0;
      while (pending_writes.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [CSR_W-1:0] value);
      drain_writes();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == CSR_LAYER_COUNT) cfg_layers = value[NL_W-1:0];
      else cfg_pixels = value[PIX_W-1:0];
      csr_writes++;
   endtask

   // Sends one pixel from the current layer on, cut at a random layer; a few
   // pixels are pure noise and a partial pixel stops early.
   task automatic send_pixel(input bit partial);
      int target;
      int limit;
      int sent;
      bit noise;
      logic [DATA_W-1:0] c;
      noise  = ($urandom_range(0, 9) == 0);
      target = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, active_layers());
      limit  = partial ? $urandom_range(1, active_layers()) : MAX_LAYERS + 1;
      sent   = 0;
      do begin
         if (noise) c = {($urandom_range(0, 1) ? 8'h00 : 8'($urandom)), 24'($urandom)};
         else if (int'(layer_pos) < target) c = {8'($urandom_range(1, 255)), 24'($urandom)};
         else if (int'(layer_pos) == target) c = {8'h00, 24'($urandom)};
         else c = $urandom;
         send_frag(c, $urandom, 0, 0);
         sent++;
      end while (layer_pos != 0 && sent < limit);
   endtask

   // Write side: random stalls, plus one long hold-off when requested.
   initial begin
      int hold_left;
      int stall_left;
      hold_left = 0;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_writes) begin
            hold_writes = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (rsp_gaps_on && $urandom_range(0, 2) == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      image_write_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         words_checked++;
         if (pending_writes.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("Unexpected store word: addr %h data %h last %b",
                        rsp_ch.write_addr, rsp_ch.write_data, rsp_ch.last);
         end else begin
            want = pending_writes.pop_front();
            if (rsp_ch.write_addr !== want.addr || rsp_ch.write_data !== want.data ||
                rsp_ch.last !== want.last) begin
               error_count++;
               if (error_count <= 10)
                  $display("Store word %0d: expected addr %h data %h last %b, got %h %h %b",
                           words_checked, want.addr, want.data, want.last,
                           rsp_ch.write_addr, rsp_ch.write_data, rsp_ch.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d store words outstanding.",
                  cycle_count, pending_writes.size());
         $display("** layered_sparse_image_rle_encoder: FAILED **");
         $finish;
      end
   end

   initial begin
      int phase;
      int quota;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.frag_color = '0;
      req_ch.frag_depth = '0;
      csr_we            = 1'b0;
      csr_index         = CSR_LAYER_COUNT;
      csr_wdata         = '0;
      cfg_layers        = LAYER_COUNT_RESET;
      cfg_pixels        = PIXEL_COUNT_RESET;
      clear_image();

      // An empty single-pixel image, then a single-fragment one.
      add_known(28'd7, 32'd1, 1'b0);
      add_known(28'd8, 32'd0, 1'b0);
      add_known(28'd9, 32'd0, 1'b0);
      add_known(28'd6, 32'd40, 1'b1);
      add_known(28'd11, 32'hFFFF_FFFF, 1'b0);
      add_known(28'd12, 32'hFFFF_FFFF, 1'b0);
      add_known(28'd10, 32'd1, 1'b0);
      add_known(28'd7, 32'd0, 1'b0);
      add_known(28'd8, 32'd1, 1'b0);
      add_known(28'd9, 32'd1, 1'b0);
      add_known(28'd6, 32'd52, 1'b1);
      add_known(28'd11, 32'h0100_0000, 1'b0);
      add_known(28'd12, 32'h0000_0000, 1'b0);
      add_known(28'd10, 32'd1, 1'b0);
      add_known(28'd7, 32'd0, 1'b0);
      add_known(28'd8, 32'd1, 1'b0);
      add_known(28'd9, 32'd1, 1'b0);
      add_known(28'd6, 32'd52, 1'b1);

      directed_rows.push_back(frag_row(32'h00FF_FFFF, 32'hFFFF_FFFF, 4, 0));
      directed_rows.push_back(frag_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7, 4));
      directed_rows.push_back(frag_row(32'h0000_0000, 32'h0000_0000, 4, 0));
      directed_rows.push_back(csr_row(CSR_LAYER_COUNT, 23'd4));
      directed_rows.push_back(csr_row(CSR_PIXEL_COUNT, 23'd3));
      directed_rows.push_back(frag_row(32'h1122_3344, 32'hA5A5_A5A5, 0, 0));
      directed_rows.push_back(frag_row(32'h80FF_00FF, 32'h5A5A_5A5A, 0, 0));
      directed_rows.push_back(frag_row(32'hFE01_0203, 32'h3F80_0000, 0, 0));
      directed_rows.push_back(frag_row(32'h01FF_FFFF, 32'hBF80_0000, 0, 0));
      directed_rows.push_back(frag_row(32'hFF00_00FF, 32'h0000_0001, 0, 0));
      directed_rows.push_back(frag_row(32'h00FF_FFFF, 32'h0000_0002, 0, 0));
      directed_rows.push_back(frag_row(32'hFFFF_FFFF, 32'h0000_0003, 0, 0));
      directed_rows.push_back(frag_row(32'h7F7F_7F7F, 32'h0000_0004, 0, 0));
      directed_rows.push_back(frag_row(32'h00AB_CDEF, 32'h0000_0005, 0, 0));
      directed_rows.push_back(frag_row(32'h1234_5678, 32'h0000_0006, 0, 0));
      directed_rows.push_back(frag_row(32'h0000_0000, 32'h0000_0007, 0, 0));
      directed_rows.push_back(frag_row(32'hFFFF_FFFF, 32'h0000_0008, 0, 0));
      directed_rows.push_back(csr_row(CSR_LAYER_COUNT, 23'd0));
      directed_rows.push_back(csr_row(CSR_PIXEL_COUNT, 23'd0));
      directed_rows.push_back(frag_row(32'h0100_0000, 32'h0000_0000, 7, 11));
      directed_rows.push_back(frag_row(32'h0000_0001, 32'hFFFF_FFFF, 4, 0));
      directed_rows.push_back(csr_row(CSR_LAYER_COUNT, 23'd2));
      directed_rows.push_back(csr_row(CSR_PIXEL_COUNT, 23'd2));
      directed_rows.push_back(frag_row(32'h0010_2030, 32'h0F0F_0F0F, 0, 0));
      directed_rows.push_back(frag_row(32'hC0C0_C0C0, 32'hF0F0_F0F0, 0, 0));
      directed_rows.push_back(frag_row(32'h4040_4040, 32'h1111_1111, 0, 0));
      directed_rows.push_back(frag_row(32'h0000_0000, 32'h2222_2222, 0, 0));
      // The layer count drops while a pixel is half sent.
      directed_rows.push_back(csr_row(CSR_LAYER_COUNT, 23'd4));
      directed_rows.push_back(frag_row(32'h9ABC_DEF0, 32'h8765_4321, 0, 0));
      directed_rows.push_back(frag_row(32'h8765_4321, 32'h1357_2468, 0, 0));
      directed_rows.push_back(csr_row(CSR_LAYER_COUNT, 23'd2));
      directed_rows.push_back(frag_row(32'hF0F0_F0F0, 32'h0F0F_0F0F, 0, 0));

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr)
            write_csr(directed_rows[i].index, directed_rows[i].value);
         else
            send_frag(directed_rows[i].color, directed_rows[i].depth,
                      directed_rows[i].known_n, directed_rows[i].known_at);
      end

      phase = 0;
      while (frags_sent < TOTAL_FRAGS) begin
         if (phase < 10) begin
            write_csr(CSR_LAYER_COUNT, 23'(layer_plan[phase]));
            write_csr(CSR_PIXEL_COUNT, 23'(pixel_plan[phase]));
         end else begin
            write_csr(CSR_LAYER_COUNT, {18'($urandom), 5'($urandom_range(0, 31))});
            if ($urandom_range(0, 1) == 1) write_csr(CSR_PIXEL_COUNT, 23'($urandom_range(0, 8)));
         end
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         if (phase == 3) hold_writes = 1'b1;
         quota = frags_sent + $urandom_range(15, 45);
         while (frags_sent < quota) send_pixel(1'b0);
         if ($urandom_range(0, 3) == 0) send_pixel(1'b1);
         phase++;
      end
      drain_writes();

      $display("Sent %0d fragment words (%0d from the table) over %0d register writes.",
               frags_sent, 24, csr_writes);
      $display("Checked %0d store words across %0d finished images.",
               words_checked, images_done);
      if (error_count == 0 && pending_writes.size() == 0) begin
         $display("** layered_sparse_image_rle_encoder: PASSED **");
      end else begin
         $display("%0d errors, %0d store words never seen.", error_count, pending_writes.size());
         $display("** layered_sparse_image_rle_encoder: FAILED **");
      end
      $finish;
   end

endmodule
